>>> rtl/bzc_pkg.sv
// Package with the types, constants and helper functions of the Bezier curve evaluator.
`timescale 1ns / 1ps
package bzc_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 32;
   localparam int WORK_W     = COORD_W + 2;
   localparam int DIFF_W     = WORK_W + 1;
   localparam int T_W        = 17;
   localparam int MULB_W     = T_W + 1;
   localparam int PROD_W     = DIFF_W + MULB_W;
   localparam int FRAC_W     = 16;
   localparam int OUT_W      = 48;
   localparam int FACT_W     = 8;

   localparam logic [T_W-1:0] T_ONE = T_W'(65536);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   localparam logic [1:0] MODE_POINT = 2'd0;
   localparam logic [1:0] MODE_SLOPE = 2'd1;
   localparam logic [1:0] MODE_BEND  = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic                      action;
      logic [3:0]                point_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [T_W-1:0]            eval_t;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] point_x;
      logic signed [OUT_W-1:0] point_y;
      logic signed [OUT_W-1:0] point_z;
      logic signed [OUT_W-1:0] slope_x;
      logic signed [OUT_W-1:0] slope_y;
      logic signed [OUT_W-1:0] slope_z;
      logic signed [OUT_W-1:0] bend_x;
      logic signed [OUT_W-1:0] bend_y;
      logic signed [OUT_W-1:0] bend_z;
   } rsp_type;

   // Clamp a full product to the signed output range.
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'({1'b0, {(OUT_W-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         sat_out = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (v < lo) begin
         sat_out = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_out = v[OUT_W-1:0];
      end
   endfunction

   // Finish one interpolation: a + floor((d*t + half) / 2^16).
   function automatic logic signed [WORK_W-1:0] interp_finish(
      input logic signed [WORK_W-1:0] a,
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      logic signed [DIFF_W-1:0] s;
      q = (p + ROUND_HALF) >>> FRAC_W;
      s = DIFF_W'(a) + q[DIFF_W-1:0];
      interp_finish = s[WORK_W-1:0];
   endfunction

endpackage

>>> rtl/bzc_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module bzc_mul (
   input  logic                                 clock,
   input  logic signed [bzc_pkg::DIFF_W-1:0]    mul_a,
   input  logic signed [bzc_pkg::MULB_W-1:0]    mul_b,
   output logic signed [bzc_pkg::PROD_W-1:0]    mul_p
);
   import bzc_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

>>> rtl/bezier_curve_point_and_derivatives.sv
// Top level of the Bezier curve evaluator: control point tables, sequencer and result register.
`timescale 1ns / 1ps
// This block evaluates a 3D Bezier curve of up to 16 control points. A load
// transaction writes one control point into the x, y and z tables and returns
// nothing. An evaluate transaction returns the curve point, the first
// derivative and the second derivative at t, each saturated to 48 bits. The
// csr port sets the number of points in use and must only be written while
// the block is idle. All multiplications by t and by the scale factor run
// through one multiplier. For each axis and each of up to three curves, the n
// points in use are read again from the table. The m working points of that
// curve are then reduced by de Casteljau steps (operands, multiply, write
// back) and a shift at the end of each round, and the remaining value is
// scaled by the factor. The block is busy from when it accepts an evaluate
// transaction until it hands over the result. It is busy longer while the
// previous result still waits to be taken, and it is not ready during that
// time. A load is written when it is accepted and leaves the block ready. A
// finished result waits in its output register, so the next transaction can
// be accepted before the previous result is taken.
module bezier_curve_point_and_derivatives (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bzc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bzc_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [bzc_pkg::CNT_W-1:0]     csr_write_data
);
   import bzc_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FILL   = 3'd1;
   localparam logic [2:0] ST_REDUCE = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_WB     = 3'd4;
   localparam logic [2:0] ST_SCALE  = 3'd5;
   localparam logic [2:0] ST_SCW    = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   // Control point tables, one per axis.
   logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
   logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
   logic signed [COORD_W-1:0] mem_z [MAX_POINTS];
   logic signed [COORD_W-1:0] rdx_ff, rdy_ff, rdz_ff;

   logic [CNT_W-1:0]  npoints_ff;
   logic [2:0]        state_ff, state_in;
   logic [1:0]        axis_ff, axis_in;
   logic [1:0]        mode_ff, mode_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  q_ff, q_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic              rdv_ff, rdv_in;
   logic [IDX_W-1:0]  rdk_ff, rdk_in;
   logic signed [WORK_W-1:0] prev1_ff, prev1_in, prev2_ff, prev2_in;
   logic signed [WORK_W-1:0] w_ff [MAX_POINTS];
   logic signed [WORK_W-1:0] w_in [MAX_POINTS];
   logic signed [OUT_W-1:0]  res_ff [3][3];
   logic signed [OUT_W-1:0]  res_in [3][3];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]  n_eff;
   logic [FACT_W-1:0] factor;
   logic [FACT_W-1:0] nm1, nm2;
   logic signed [DIFF_W-1:0] mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [WORK_W-1:0] cur;
   logic signed [WORK_W-1:0] push_val;
   logic              last_part;
   logic              accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A point count above the table size uses the whole table.
   assign n_eff = (npoints_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : npoints_ff;
   assign nm1   = FACT_W'(n_eff) - FACT_W'(1);
   assign nm2   = FACT_W'(n_eff) - FACT_W'(2);

   always_comb begin
      case (mode_ff)
         MODE_POINT: factor = FACT_W'(1);
         MODE_SLOPE: factor = nm1;
         MODE_BEND:  factor = FACT_W'(nm1 * nm2);
         default:    factor = FACT_W'(0);
      endcase
   end

   // The part just finished is the last one of this axis when no further
   // difference order has enough points.
   assign last_part = (mode_ff == MODE_BEND) || (n_eff <= CNT_W'(mode_ff) + CNT_W'(1));

   always_comb begin
      case (axis_ff)
         AXIS_X:  cur = WORK_W'(rdx_ff);
         AXIS_Y:  cur = WORK_W'(rdy_ff);
         default: cur = WORK_W'(rdz_ff);
      endcase
   end

   always_comb begin
      case (mode_ff)
         MODE_POINT: push_val = cur;
         MODE_SLOPE: push_val = cur - prev1_ff;
         default:    push_val = cur - (prev1_ff <<< 1) + prev2_ff;
      endcase
   end

   // Operand selection for the shared multiplier: an interpolation step
   // multiplies the neighbor difference by t, scaling multiplies by the factor.
   always_comb begin
      if (state_ff == ST_SCALE) begin
         mul_a = DIFF_W'(w_ff[0]);
         mul_b = MULB_W'(factor);
      end else begin
         mul_a = DIFF_W'(w_ff[1]) - DIFF_W'(w_ff[0]);
         mul_b = MULB_W'(t_ff);
      end
   end

   bzc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACT_LOAD) begin
         mem_x[req_data.point_index[IDX_W-1:0]] <= req_data.coord_x;
         mem_y[req_data.point_index[IDX_W-1:0]] <= req_data.coord_y;
         mem_z[req_data.point_index[IDX_W-1:0]] <= req_data.coord_z;
      end
      rdx_ff <= mem_x[k_ff[IDX_W-1:0]];
      rdy_ff <= mem_y[k_ff[IDX_W-1:0]];
      rdz_ff <= mem_z[k_ff[IDX_W-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      mode_in      = mode_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      j_in         = j_ff;
      rdv_in       = 1'b0;
      rdk_in       = rdk_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      w_in         = w_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.action == ACT_EVAL) begin
               t_in    = (req_data.eval_t > T_ONE) ? T_ONE : req_data.eval_t;
               axis_in = AXIS_X;
               mode_in = MODE_POINT;
               k_in    = '0;
               q_in    = '0;
               for (int a = 0; a < 3; a++) begin
                  for (int m = 0; m < 3; m++) begin
                     res_in[a][m] = '0;
                  end
               end
               state_in = (n_eff == '0) ? ST_DONE : ST_FILL;
            end
         end
         ST_FILL: begin
            // Reads are issued from k while data returns in the next cycle.
            if (k_ff < n_eff) begin
               rdv_in = 1'b1;
               rdk_in = k_ff[IDX_W-1:0];
               k_in   = k_ff + CNT_W'(1);
            end
            if (rdv_ff) begin
               prev1_in = cur;
               prev2_in = prev1_ff;
               if (CNT_W'(rdk_ff) >= CNT_W'(mode_ff)) begin
                  w_in[q_ff[IDX_W-1:0]] = push_val;
                  q_in = q_ff + CNT_W'(1);
               end
               if (CNT_W'(rdk_ff) == n_eff - CNT_W'(1)) begin
                  j_in     = '0;
                  rdv_in   = 1'b0;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (q_ff == CNT_W'(1)) begin
               state_in = ST_SCALE;
            end else if (j_ff == q_ff - CNT_W'(1)) begin
               // End of a round: the last old point is dropped.
               for (int i = 0; i < MAX_POINTS - 1; i++) begin
                  w_in[i] = w_ff[i+1];
               end
               q_in = q_ff - CNT_W'(1);
               j_in = '0;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            for (int i = 0; i < MAX_POINTS - 1; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[IDX_W'(q_ff - CNT_W'(1))] = interp_finish(w_ff[0], mul_p);
            j_in     = j_ff + CNT_W'(1);
            state_in = ST_REDUCE;
         end
         ST_SCALE: begin
            state_in = ST_SCW;
         end
         ST_SCW: begin
            res_in[axis_ff][mode_ff] = sat_out(mul_p);
            k_in = '0;
            q_in = '0;
            if (!last_part) begin
               mode_in  = mode_ff + 2'd1;
               state_in = ST_FILL;
            end else if (axis_ff != AXIS_Z) begin
               axis_in  = axis_ff + 2'd1;
               mode_in  = MODE_POINT;
               state_in = ST_FILL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand over once the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.point_x = res_in[AXIS_X][MODE_POINT];
               rsp_in.point_y = res_in[AXIS_Y][MODE_POINT];
               rsp_in.point_z = res_in[AXIS_Z][MODE_POINT];
               rsp_in.slope_x = res_in[AXIS_X][MODE_SLOPE];
               rsp_in.slope_y = res_in[AXIS_Y][MODE_SLOPE];
               rsp_in.slope_z = res_in[AXIS_Z][MODE_SLOPE];
               rsp_in.bend_x  = res_in[AXIS_X][MODE_BEND];
               rsp_in.bend_y  = res_in[AXIS_Y][MODE_BEND];
               rsp_in.bend_z  = res_in[AXIS_Z][MODE_BEND];
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         npoints_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= rdv_in;
         if (csr_write_enable) begin
            npoints_ff <= csr_write_data;
         end
      end
      axis_ff  <= axis_in;
      mode_ff  <= mode_in;
      t_ff     <= t_in;
      k_ff     <= k_in;
      q_ff     <= q_in;
      j_ff     <= j_in;
      rdk_ff   <= rdk_in;
      prev1_ff <= prev1_in;
      prev2_ff <= prev2_in;
      w_ff     <= w_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

endmodule

>>> rtl/bzc_check.sv
// Port-level checks of the Bezier curve evaluator and their binding to the top level.
`timescale 1ns / 1ps
module bzc_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bzc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bzc_pkg::rsp_type rsp_data
);
   import bzc_pkg::*;

   // A result that is not taken stays offered unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A load transaction never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.action == ACT_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load produced a result");

   // An evaluate transaction keeps the block busy in the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.action == ACT_EVAL |=> !req_ready)
      else $error("ready right after an evaluate");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind bezier_curve_point_and_derivatives bzc_check u_bzc_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
